### rtl/core/csrab_pkg.sv
package csrab_pkg;

   localparam int ID_W     = 12;
   localparam int DEG_W    = 15;
   localparam int NC_W     = 13;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int RAW_W    = 2 * ID_W;

   localparam int MAX_NODES_DEFAULT  = 4096;
   localparam int MAX_EDGES_DEFAULT  = 16384;
   localparam int MAX_LISTED_DEFAULT = 64;

   localparam logic [NC_W-1:0] NODE_COUNT_RESET = NC_W'(4096);

   localparam logic CSR_NODE_COUNT = 1'b0;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_PHASE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B_ZERO,
      ST_B_CNT_RD,
      ST_B_CNT_OFF,
      ST_B_CNT_WR,
      ST_B_PS_RD,
      ST_B_PS_WR,
      ST_B_PL_RD,
      ST_B_PL_CUR,
      ST_B_PL_WR,
      ST_B_DONE,
      ST_Q_A,
      ST_Q_B,
      ST_Q_NONE,
      ST_Q_EMIT
   } ctrl_state_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   neighbour_id;
      logic              neighbour_valid;
      logic [DEG_W-1:0]  degree;
      logic              truncated;
      logic              last;
   } rsp_item_type;

endpackage

### rtl/core/csrab_ram.sv
module csrab_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/csrab_rsp_fifo.sv
module csrab_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  csrab_pkg::rsp_item_type  push_item,
   input  logic                     out_ready,
   output logic                     out_valid,
   output csrab_pkg::rsp_item_type  out_item,
   output logic [1:0]               count,
   output logic                     pop
);
   import csrab_pkg::*;

   rsp_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      out_valid = (count_ff != 2'd0);
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign out_item = entry_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

### rtl/core/csrab_ctrl.sv
module csrab_ctrl #(
   parameter int MAX_NODES  = csrab_pkg::MAX_NODES_DEFAULT,
   parameter int MAX_EDGES  = csrab_pkg::MAX_EDGES_DEFAULT,
   parameter int MAX_LISTED = csrab_pkg::MAX_LISTED_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [csrab_pkg::NC_W-1:0]     active_nodes,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  csrab_pkg::op_type              req_op,
   input  logic [csrab_pkg::ID_W-1:0]     req_source,
   input  logic [csrab_pkg::ID_W-1:0]     req_target,
   input  logic [csrab_pkg::ID_W-1:0]     req_query,
   output logic                           push,
   output csrab_pkg::rsp_item_type        push_item,
   input  logic [1:0]                     fifo_count,
   input  logic                           fifo_pop
);
   import csrab_pkg::*;

   localparam int NODE_AW   = $clog2(MAX_NODES);
   localparam int OFF_DEPTH = MAX_NODES + 1;
   localparam int OFF_AW    = $clog2(MAX_NODES + 1);
   localparam int EDGE_AW   = $clog2(MAX_EDGES);
   localparam int EDGE_CW   = $clog2(MAX_EDGES + 1);
   localparam int LIST_W    = $clog2(MAX_LISTED + 1);

   localparam logic [OFF_AW-1:0]  LAST_ROW  = OFF_AW'(MAX_NODES);
   localparam logic [EDGE_CW-1:0] EDGE_FULL = EDGE_CW'(MAX_EDGES);

   ctrl_state_type state_ff, state_in;

   logic [EDGE_CW-1:0] edges_held_ff, edges_held_in;
   logic               built_ff, built_in;
   logic [OFF_AW-1:0]  idx_ff, idx_in;
   logic [EDGE_CW-1:0] e_ff, e_in;
   logic [EDGE_CW-1:0] acc_ff, acc_in;
   logic [OFF_AW-1:0]  cnt_addr_ff, cnt_addr_in;
   logic [NODE_AW-1:0] src_ff, src_in;
   logic [ID_W-1:0]    tgt_ff, tgt_in;
   logic [ID_W-1:0]    q_ff, q_in;
   logic [EDGE_CW-1:0] start_ff, start_in;
   logic [EDGE_CW-1:0] deg_ff, deg_in;
   logic               trunc_ff, trunc_in;
   logic [LIST_W-1:0]  lim_ff, lim_in;
   logic [LIST_W-1:0]  k_ff, k_in;
   logic               inflight_ff, inflight_in;
   logic               last_ff, last_in;

   logic               raw_we, raw_re;
   logic [EDGE_AW-1:0] raw_waddr, raw_raddr;
   logic [RAW_W-1:0]   raw_wdata, raw_rd;

   logic               off_we, off_re;
   logic [OFF_AW-1:0]  off_waddr, off_raddr;
   logic [EDGE_CW-1:0] off_wdata, off_rd;

   logic               cur_we, cur_re;
   logic [NODE_AW-1:0] cur_waddr, cur_raddr;
   logic [EDGE_CW-1:0] cur_wdata, cur_rd;

   logic               grp_we, grp_re;
   logic [EDGE_AW-1:0] grp_waddr, grp_raddr;
   logic [ID_W-1:0]    grp_wdata, grp_rd;

   logic [1:0]         occ;
   logic               room;
   logic               accept;
   logic               src_ok, tgt_ok, q_ok;
   logic [ID_W-1:0]    raw_src, raw_tgt;
   logic [EDGE_CW-1:0] q_deg;
   logic [EDGE_CW-1:0] ps_sum;
   logic [EDGE_CW-1:0] emit_pos;
   logic               e_last;

   csrab_ram #(.DEPTH(MAX_EDGES), .WIDTH(RAW_W)) u_raw (
      .clock   (clock),
      .wr_en   (raw_we),
      .wr_addr (raw_waddr),
      .wr_data (raw_wdata),
      .rd_en   (raw_re),
      .rd_addr (raw_raddr),
      .rd_data (raw_rd)
   );

   csrab_ram #(.DEPTH(OFF_DEPTH), .WIDTH(EDGE_CW)) u_off (
      .clock   (clock),
      .wr_en   (off_we),
      .wr_addr (off_waddr),
      .wr_data (off_wdata),
      .rd_en   (off_re),
      .rd_addr (off_raddr),
      .rd_data (off_rd)
   );

   csrab_ram #(.DEPTH(MAX_NODES), .WIDTH(EDGE_CW)) u_cur (
      .clock   (clock),
      .wr_en   (cur_we),
      .wr_addr (cur_waddr),
      .wr_data (cur_wdata),
      .rd_en   (cur_re),
      .rd_addr (cur_raddr),
      .rd_data (cur_rd)
   );

   csrab_ram #(.DEPTH(MAX_EDGES), .WIDTH(ID_W)) u_grp (
      .clock   (clock),
      .wr_en   (grp_we),
      .wr_addr (grp_waddr),
      .wr_data (grp_wdata),
      .rd_en   (grp_re),
      .rd_addr (grp_raddr),
      .rd_data (grp_rd)
   );

   always_comb begin
      occ       = fifo_count + {1'b0, inflight_ff};
      room      = (occ < 2'd2) || fifo_pop;
      req_ready = (state_ff == ST_IDLE) && !inflight_ff && room;
      accept    = req_valid && req_ready;
      src_ok    = ({1'b0, req_source} < active_nodes);
      tgt_ok    = ({1'b0, req_target} < active_nodes);
      q_ok      = ({1'b0, req_query} < active_nodes);
      raw_src   = raw_rd[RAW_W-1:ID_W];
      raw_tgt   = raw_rd[ID_W-1:0];
      q_deg     = off_rd - start_ff;
      ps_sum    = acc_ff + off_rd;
      emit_pos  = start_ff + EDGE_CW'(k_ff);
      e_last    = ((e_ff + EDGE_CW'(1)) == edges_held_ff);
   end

   always_comb begin
      state_in      = state_ff;
      edges_held_in = edges_held_ff;
      built_in      = built_ff;
      idx_in        = idx_ff;
      e_in          = e_ff;
      acc_in        = acc_ff;
      cnt_addr_in   = cnt_addr_ff;
      src_in        = src_ff;
      tgt_in        = tgt_ff;
      q_in          = q_ff;
      start_in      = start_ff;
      deg_in        = deg_ff;
      trunc_in      = trunc_ff;
      lim_in        = lim_ff;
      k_in          = k_ff;
      inflight_in   = 1'b0;
      last_in       = last_ff;

      raw_we    = 1'b0;
      raw_waddr = edges_held_ff[EDGE_AW-1:0];
      raw_wdata = {req_source, req_target};
      raw_re    = 1'b0;
      raw_raddr = e_ff[EDGE_AW-1:0];

      off_we    = 1'b0;
      off_waddr = idx_ff;
      off_wdata = '0;
      off_re    = 1'b0;
      off_raddr = idx_ff;

      cur_we    = 1'b0;
      cur_waddr = src_ff;
      cur_wdata = cur_rd + EDGE_CW'(1);
      cur_re    = 1'b0;
      cur_raddr = NODE_AW'(raw_src);

      grp_we    = 1'b0;
      grp_waddr = cur_rd[EDGE_AW-1:0];
      grp_wdata = tgt_ff;
      grp_re    = 1'b0;
      grp_raddr = emit_pos[EDGE_AW-1:0];

      push                      = 1'b0;
      push_item.status          = STATUS_OK;
      push_item.neighbour_id    = '0;
      push_item.neighbour_valid = 1'b0;
      push_item.degree          = '0;
      push_item.truncated       = 1'b0;
      push_item.last            = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_ADD: begin
                     push = 1'b1;
                     if (built_ff) begin
                        push_item.status = STATUS_PHASE;
                     end else if (!src_ok || !tgt_ok) begin
                        push_item.status = STATUS_RANGE;
                     end else if (edges_held_ff == EDGE_FULL) begin
                        push_item.status = STATUS_FULL;
                     end else begin
                        raw_we        = 1'b1;
                        edges_held_in = edges_held_ff + EDGE_CW'(1);
                     end
                  end
                  OP_BUILD: begin
                     idx_in   = '0;
                     state_in = ST_B_ZERO;
                  end
                  OP_QUERY: begin
                     if (!built_ff) begin
                        push             = 1'b1;
                        push_item.status = STATUS_PHASE;
                     end else if (!q_ok) begin
                        push             = 1'b1;
                        push_item.status = STATUS_RANGE;
                     end else begin
                        off_re    = 1'b1;
                        off_raddr = OFF_AW'(req_query);
                        q_in      = req_query;
                        state_in  = ST_Q_A;
                     end
                  end
                  OP_CLEAR: begin
                     push          = 1'b1;
                     edges_held_in = '0;
                     built_in      = 1'b0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // build: zero rows, count degrees, prefix sum, place targets
         ST_B_ZERO: begin
            off_we = 1'b1;
            if (idx_ff == LAST_ROW) begin
               idx_in   = '0;
               e_in     = '0;
               acc_in   = '0;
               state_in = (edges_held_ff == '0) ? ST_B_PS_RD : ST_B_CNT_RD;
            end else begin
               idx_in = idx_ff + OFF_AW'(1);
            end
         end
         ST_B_CNT_RD: begin
            raw_re   = 1'b1;
            state_in = ST_B_CNT_OFF;
         end
         ST_B_CNT_OFF: begin
            off_re      = 1'b1;
            off_raddr   = OFF_AW'(raw_src) + OFF_AW'(1);
            cnt_addr_in = OFF_AW'(raw_src) + OFF_AW'(1);
            state_in    = ST_B_CNT_WR;
         end
         ST_B_CNT_WR: begin
            off_we    = 1'b1;
            off_waddr = cnt_addr_ff;
            off_wdata = off_rd + EDGE_CW'(1);
            e_in      = e_ff + EDGE_CW'(1);
            state_in  = e_last ? ST_B_PS_RD : ST_B_CNT_RD;
         end
         ST_B_PS_RD: begin
            off_re   = 1'b1;
            state_in = ST_B_PS_WR;
         end
         ST_B_PS_WR: begin
            off_we    = 1'b1;
            off_wdata = ps_sum;
            acc_in    = ps_sum;
            if (idx_ff != LAST_ROW) begin
               cur_we    = 1'b1;
               cur_waddr = NODE_AW'(idx_ff);
               cur_wdata = ps_sum;
               idx_in    = idx_ff + OFF_AW'(1);
               state_in  = ST_B_PS_RD;
            end else begin
               e_in     = '0;
               state_in = (edges_held_ff == '0) ? ST_B_DONE : ST_B_PL_RD;
            end
         end
         ST_B_PL_RD: begin
            raw_re   = 1'b1;
            state_in = ST_B_PL_CUR;
         end
         ST_B_PL_CUR: begin
            cur_re   = 1'b1;
            src_in   = NODE_AW'(raw_src);
            tgt_in   = raw_tgt;
            state_in = ST_B_PL_WR;
         end
         ST_B_PL_WR: begin
            grp_we   = 1'b1;
            cur_we   = 1'b1;
            e_in     = e_ff + EDGE_CW'(1);
            state_in = e_last ? ST_B_DONE : ST_B_PL_RD;
         end
         ST_B_DONE: begin
            if (room) begin
               push             = 1'b1;
               push_item.degree = DEG_W'(edges_held_ff);
               built_in         = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         // query: fetch row bounds, then stream targets
         ST_Q_A: begin
            start_in  = off_rd;
            off_re    = 1'b1;
            off_raddr = OFF_AW'(q_ff) + OFF_AW'(1);
            state_in  = ST_Q_B;
         end
         ST_Q_B: begin
            deg_in   = q_deg;
            trunc_in = (q_deg > MAX_LISTED);
            lim_in   = (q_deg > MAX_LISTED) ? LIST_W'(MAX_LISTED) : LIST_W'(q_deg);
            k_in     = '0;
            state_in = (q_deg == '0) ? ST_Q_NONE : ST_Q_EMIT;
         end
         ST_Q_NONE: begin
            if (room) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_Q_EMIT: begin
            if (room) begin
               grp_re      = 1'b1;
               inflight_in = 1'b1;
               last_in     = ((k_ff + LIST_W'(1)) == lim_ff);
               k_in        = k_ff + LIST_W'(1);
               if ((k_ff + LIST_W'(1)) == lim_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (inflight_ff) begin
         push                      = 1'b1;
         push_item.status          = STATUS_OK;
         push_item.neighbour_id    = grp_rd;
         push_item.neighbour_valid = 1'b1;
         push_item.degree          = DEG_W'(deg_ff);
         push_item.truncated       = trunc_ff;
         push_item.last            = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         edges_held_ff <= '0;
         built_ff      <= 1'b0;
         inflight_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edges_held_ff <= edges_held_in;
         built_ff      <= built_in;
         inflight_ff   <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      e_ff        <= e_in;
      acc_ff      <= acc_in;
      cnt_addr_ff <= cnt_addr_in;
      src_ff      <= src_in;
      tgt_ff      <= tgt_in;
      q_ff        <= q_in;
      start_ff    <= start_in;
      deg_ff      <= deg_in;
      trunc_ff    <= trunc_in;
      lim_ff      <= lim_in;
      k_ff        <= k_in;
      last_ff     <= last_in;
   end

endmodule

### rtl/core/csr_adjacency_build_and_query_unit.sv
// channel   | handshake                      | payload
// ----------+--------------------------------+------------------------------------------
// req       | req_tvalid / req_tready        | req_tuser operation, req_tdata edge/query
// rsp       | rsp_tvalid / rsp_tready        | rsp_tuser status, rsp_tdata, rsp_tlast
// csr       | csr_psel / csr_penable         | node_count at byte address 0
//
// Add and clear are answered from the idle state; query reads the row bounds in ST_Q_A and
// ST_Q_B, then one neighbour per cycle while the queue has room, from the grouped target
// memory (single read port). Build: N+1 row clears, a count pass over the edges, a prefix
// sum over the N+1 rows, a placement pass over the edges, then a done response; N = MAX_NODES.
// Reset is synchronous; no memory sweep follows it. Results sit in a 2-entry queue so
// a stalled rsp side holds the request side only once the queue is full.
module csr_adjacency_build_and_query_unit #(
   parameter int MAX_NODES  = csrab_pkg::MAX_NODES_DEFAULT,
   parameter int MAX_EDGES  = csrab_pkg::MAX_EDGES_DEFAULT,
   parameter int MAX_LISTED = csrab_pkg::MAX_LISTED_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [39:0]                    req_tdata,   // edge_source, edge_target, query_node
   input  logic [1:0]                     req_tuser,   // operation

   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,   // neighbour_id, neighbour_valid,
                                                       // degree, truncated
   output logic [1:0]                     rsp_tuser,   // status
   output logic                           rsp_tlast,

   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [csrab_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [csrab_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [csrab_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                           csr_pready
);
   import csrab_pkg::*;

   logic [NC_W-1:0] node_count_ff, node_count_in;
   logic [NC_W-1:0] active_nodes;
   logic            csr_wr;

   logic            push;
   rsp_item_type    push_item;
   rsp_item_type    out_item;
   logic [1:0]      fifo_count;
   logic            fifo_pop;

   assign csr_pready = 1'b1;

   always_comb begin
      csr_wr        = csr_psel && csr_penable && csr_pwrite && csr_pready;
      node_count_in = node_count_ff;
      if (csr_wr && (csr_paddr[2] == CSR_NODE_COUNT)) begin
         node_count_in = csr_pwdata[NC_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_NODE_COUNT) begin
         csr_prdata = CSR_DW'(node_count_ff);
      end
      if (node_count_ff == '0) begin
         active_nodes = NC_W'(1);
      end else if (node_count_ff > MAX_NODES) begin
         active_nodes = NC_W'(MAX_NODES);
      end else begin
         active_nodes = node_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   csrab_ctrl #(
      .MAX_NODES  (MAX_NODES),
      .MAX_EDGES  (MAX_EDGES),
      .MAX_LISTED (MAX_LISTED)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .active_nodes (active_nodes),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (op_type'(req_tuser)),
      .req_source   (req_tdata[11:0]),
      .req_target   (req_tdata[23:12]),
      .req_query    (req_tdata[35:24]),
      .push         (push),
      .push_item    (push_item),
      .fifo_count   (fifo_count),
      .fifo_pop     (fifo_pop)
   );

   csrab_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .count     (fifo_count),
      .pop       (fifo_pop)
   );

   assign rsp_tdata = {3'b000, out_item.truncated, out_item.degree,
                       out_item.neighbour_valid, out_item.neighbour_id};
   assign rsp_tuser = out_item.status;
   assign rsp_tlast = out_item.last;

endmodule
